### design/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 digest core.
package sha_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } qword_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### design/sha256_message_digest_core.sv
// SHA-256 digest core: one message byte per input beat, eight digest words per message.
// Throughput: one byte beat per cycle into the packer while it is not padding and the
// four-word queue is not full; each 64-byte block is loaded as 16 words, run through 64
// rounds in the single-round engine and then added, and the queue holds only 16 bytes meanwhile.
// After the final beat: padding bytes, one or two compressions, then 8 digest beats.
// Reset: asynchronous, clears counters and queue and loads the SHA-256 initial values.
module sha256_message_digest_core import sha_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  logic   push, full, pop, qvalid;
  qword_t push_data, pop_data;

  sha_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .message_byte_i   (message_byte_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .push_o           (push),
    .push_data_o      (push_data),
    .full_i           (full)
  );

  sha_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (qvalid),
    .pop_data_o  (pop_data)
  );

  sha_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (qvalid),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

### design/sha_front.sv
// Byte packer and padding generator: turns message beats into 32-bit schedule words.
module sha_front import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        push_o,
  output qword_t      push_data_o,
  input  logic        full_i
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MARK = 4'b0010,
    F_ZERO = 4'b0100,
    F_LEN  = 4'b1000
  } front_e;

  front_e      state_q, state_d;
  logic [5:0]  pos_q, pos_d;
  logic [23:0] acc_q, acc_d;
  logic [63:0] cnt_q, cnt_d;
  logic [63:0] len_q, len_d;

  logic       accept, byte_v, byte_fire, word_end;
  logic [7:0] byte_d;

  assign in_ready_o = (state_q == F_IDLE) && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign word_end   = (pos_q[1:0] == 2'b11);

  always_comb begin
    byte_v = 1'b0;
    byte_d = 8'h00;
    case (state_q)
      F_IDLE: begin
        byte_v = accept && byte_present_i;
        byte_d = message_byte_i;
      end
      F_MARK: begin
        byte_v = 1'b1;
        byte_d = 8'h80;
      end
      F_ZERO: begin
        byte_v = (pos_q != 6'd56);
      end
      F_LEN: begin
        byte_v = 1'b1;
        byte_d = len_q[63:56];
      end
      default: ;
    endcase
  end

  assign byte_fire        = byte_v && !(word_end && full_i);
  assign push_o           = byte_fire && word_end;
  assign push_data_o.word = {acc_q, byte_d};
  assign push_data_o.last = (state_q == F_LEN) && (pos_q == 6'd63);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    if (byte_fire) begin
      pos_d = pos_q + 6'd1;
      acc_d = {acc_q[15:0], byte_d};
    end
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (end_of_message_i) begin
            len_d   = cnt_q + (byte_present_i ? 64'd8 : 64'd0);
            cnt_d   = '0;
            state_d = F_MARK;
          end else if (byte_present_i) begin
            cnt_d = cnt_q + 64'd8;
          end
        end
      end
      F_MARK: begin
        if (byte_fire) state_d = F_ZERO;
      end
      F_ZERO: begin
        if (pos_q == 6'd56) state_d = F_LEN;
      end
      F_LEN: begin
        if (byte_fire) begin
          len_d = {len_q[55:0], 8'h00};
          if (pos_q == 6'd63) state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    len_q <= len_d;
  end

endmodule

### design/sha_fifo.sv
// Short word queue between the byte front end and the compression back end.
module sha_fifo import sha_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  qword_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output qword_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qword_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wrap_inc(wptr_q);
      if (pop_i)  rptr_q <= wrap_inc(rptr_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### design/sha_back.sv
// Compression engine: schedule window, one round per cycle, chaining update and digest beats.
module sha_back import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  input  qword_t      pop_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [3:0] {
    B_LOAD  = 4'b0001,
    B_ROUND = 4'b0010,
    B_ADD   = 4'b0100,
    B_OUT   = 4'b1000
  } back_e;

  back_e       state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        final_q, final_d;
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] h_q [8];
  logic [31:0] h_d [8];
  logic        ovalid_q, ovalid_d;
  logic [31:0] oword_q, oword_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        olast_q, olast_d;

  logic [31:0] w_next, t1, t2;

  assign pop_o  = (state_q == B_LOAD) && pop_valid_i;
  assign w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
  assign t1     = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
                + RoundK[cnt_q] + w_q[0];
  assign t2     = big_sigma0(v_q[0])
                + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign out_valid_o   = ovalid_q;
  assign digest_word_o = oword_q;
  assign word_index_o  = oidx_q;
  assign last_word_o   = olast_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    final_d  = final_q;
    w_d      = w_q;
    v_d      = v_q;
    h_d      = h_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oword_d  = oword_q;
    oidx_d   = oidx_q;
    olast_d  = olast_q;
    case (state_q)
      B_LOAD: begin
        if (pop_o) begin
          for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
          w_d[15] = pop_data_i.word;
          cnt_d   = cnt_q + 6'd1;
          if (cnt_q == 6'd15) begin
            final_d = pop_data_i.last;
            v_d     = h_q;
            cnt_d   = '0;
            state_d = B_ROUND;
          end
        end
      end
      B_ROUND: begin
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = w_next;
        v_d[7]  = v_q[6];
        v_d[6]  = v_q[5];
        v_d[5]  = v_q[4];
        v_d[4]  = v_q[3] + t1;
        v_d[3]  = v_q[2];
        v_d[2]  = v_q[1];
        v_d[1]  = v_q[0];
        v_d[0]  = t1 + t2;
        cnt_d   = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = B_ADD;
      end
      B_ADD: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        cnt_d   = '0;
        state_d = final_q ? B_OUT : B_LOAD;
      end
      B_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oword_d  = h_q[cnt_q[2:0]];
          oidx_d   = cnt_q[2:0];
          olast_d  = (cnt_q[2:0] == 3'd7);
          cnt_d    = cnt_q + 6'd1;
          if (cnt_q[2:0] == 3'd7) begin
            h_d     = InitH;
            cnt_d   = '0;
            state_d = B_LOAD;
          end
        end
      end
      default: state_d = B_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_LOAD;
      cnt_q    <= '0;
      final_q  <= 1'b0;
      h_q      <= InitH;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      final_q  <= final_d;
      h_q      <= h_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    v_q     <= v_d;
    oword_q <= oword_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

endmodule
